FILE: hw/rtl/serial_command_frame_decoder_top_assert.svh
// Assertion macros shared by the decoder RTL.
`ifndef SERIAL_COMMAND_FRAME_DECODER_TOP_ASSERT_SVH
`define SERIAL_COMMAND_FRAME_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("decoder assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SCFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("decoder assertion failed");

`endif

FILE: hw/rtl/scfd_pkg.sv
`default_nettype none

package scfd_pkg;

    // Field widths of the input and result items.
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned ID_W     = 7;
    localparam int unsigned VALUE_W  = 13;
    localparam int unsigned MAG_W    = 12;
    localparam int unsigned ACTION_W = 4;
    localparam int unsigned MOTOR_W  = 2;
    localparam int unsigned CNT_OUT_W = 32;
    localparam int unsigned LIMIT_W  = 12;

    // Result tdata: command_id, frame_value, action, motor_index, imu_reinit,
    // bytes_counted, failures_counted, padded to whole bytes.
    localparam int unsigned OUT_FIELDS_W = ID_W + VALUE_W + ACTION_W + MOTOR_W + 1
                                           + 2 * CNT_OUT_W;
    localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Limits and reset values.
    localparam logic [MAG_W-1:0]   MAG_MAX          = 12'd2048;
    localparam logic [LIMIT_W-1:0] POWER_LIMIT_INIT = 12'd100;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_NONE      = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_SET_POWER = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_BRAKE     = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_FLOAT     = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_RESET_CNT = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_COLOR     = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_ULTRA     = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_GYRO_RST  = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_OTHER     = 4'd8;
    localparam logic [ACTION_W-1:0] ACT_POWER_IGN = 4'd9;

    // Command ids.
    localparam logic [ID_W-1:0] CMD_POWER_FIRST = 7'd1;
    localparam logic [ID_W-1:0] CMD_POWER_LAST  = 7'd3;
    localparam logic [ID_W-1:0] CMD_STOP_FIRST  = 7'd5;
    localparam logic [ID_W-1:0] CMD_STOP_LAST   = 7'd7;
    localparam logic [ID_W-1:0] CMD_RCNT_FIRST  = 7'd9;
    localparam logic [ID_W-1:0] CMD_RCNT_LAST   = 7'd11;
    localparam logic [ID_W-1:0] CMD_GYRO_RST    = 7'd13;
    localparam logic [ID_W-1:0] CMD_COLOR       = 7'd61;
    localparam logic [ID_W-1:0] CMD_ULTRA       = 7'd62;

endpackage

`default_nettype wire

FILE: hw/rtl/serial_command_frame_decoder_top.sv
// Serial command frame decoder.
// Input stream: one received byte per transfer on the s_axis group (tdata
// bits 7:0). A byte with bit 7 set opens a frame; two data bytes follow.
// Output stream: exactly one result per input byte on the m_axis group;
// tlast marks a completed, in-range frame and tuser flags a framing or
// range failure caused by that byte.
// The result is registered and appears in the cycle after the input transfer.
// Throughput: one byte per cycle while m_axis tready stays high; the parse
// state and both counters are updated in the same cycle from a single
// compare-and-decode stage that feeds the result register.
// Stall: while a result waits with tready low, s_axis tready drops, since
// the result register is the only storage; when the result is taken, a
// new byte is accepted in that same cycle.
// Reset (synchronous, active low): parser hunts for a command byte, held
// bytes and counters clear, power_limit returns to 100, no result pending.
// Configuration: i_cfg_we writes power_limit; write only while idle.
`default_nettype none

`include "serial_command_frame_decoder_top_assert.svh"

module serial_command_frame_decoder_top #(
    parameter int unsigned COUNTER_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write of power_limit.
    input  wire logic        i_cfg_we,
    input  wire logic [scfd_pkg::LIMIT_W-1:0] i_cfg_wdata,
    // Input stream.
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [scfd_pkg::BYTE_W-1:0] i_s_axis_tdata,  // [7:0] rx_byte
    // Result stream.
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [6:0] command_id, [19:7] frame_value, [23:20] action,
    // [25:24] motor_index, [26] imu_reinit, [58:27] bytes_counted,
    // [90:59] failures_counted, [95:91] zero
    output logic [scfd_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic             o_m_axis_tlast,                  // frame_done
    output logic             o_m_axis_tuser                   // [0] frame_error
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_DATA1,
        PH_DATA2
    } t_phase;

    localparam int unsigned CW = COUNTER_BITS;

    t_phase r_phase, n_phase;
    logic [scfd_pkg::ID_W-1:0]     r_cmd, n_cmd;
    logic [scfd_pkg::ID_W-1:0]     r_first, n_first;
    logic [CW-1:0]                 r_byte_cnt, n_byte_cnt;
    logic [CW-1:0]                 r_fail_cnt, n_fail_cnt;
    logic [scfd_pkg::LIMIT_W-1:0]  r_power_limit;

    logic                          r_valid;
    logic                          r_done, n_done;
    logic [scfd_pkg::ID_W-1:0]     r_cid, n_cid;
    logic [scfd_pkg::VALUE_W-1:0]  r_fval, n_fval;
    logic [scfd_pkg::ACTION_W-1:0] r_act, n_act;
    logic [scfd_pkg::MOTOR_W-1:0]  r_motor, n_motor;
    logic                          r_imu, n_imu;
    logic                          r_err, n_err;

    logic                          in_xfer;
    logic                          marked;
    logic [scfd_pkg::ID_W-1:0]     low7;
    logic [scfd_pkg::MAG_W-1:0]    mag;
    logic                          sign;
    logic                          in_range;
    logic                          value_is_one;
    logic [scfd_pkg::VALUE_W-1:0]  value;
    logic [scfd_pkg::ACTION_W-1:0] dec_act;
    logic [scfd_pkg::MOTOR_W-1:0]  dec_motor;
    logic                          dec_imu;
    logic [scfd_pkg::CNT_OUT_W-1:0] bytes_out, fails_out;

    // The result register frees up in the same cycle its result is taken.
    assign o_s_axis_tready = !r_valid || i_m_axis_tready;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    assign marked = i_s_axis_tdata[7];
    assign low7   = i_s_axis_tdata[6:0];

    // Sign-magnitude value from the held first data byte and this byte.
    assign mag          = {r_first[4:0], low7};
    assign sign         = r_first[5];
    assign in_range     = (mag <= scfd_pkg::MAG_MAX);
    assign value_is_one = !sign && (mag == scfd_pkg::MAG_W'(1));
    assign value        = sign ? scfd_pkg::VALUE_W'(-{1'b0, mag}) : {1'b0, mag};

    // Action decode of the held command.
    always_comb begin
        dec_act   = scfd_pkg::ACT_OTHER;
        dec_motor = '0;
        dec_imu   = 1'b0;
        priority if (r_cmd >= scfd_pkg::CMD_POWER_FIRST && r_cmd <= scfd_pkg::CMD_POWER_LAST) begin
            dec_motor = scfd_pkg::MOTOR_W'(r_cmd[1:0] - 2'd1);
            dec_act   = (mag <= r_power_limit) ? scfd_pkg::ACT_SET_POWER
                                               : scfd_pkg::ACT_POWER_IGN;
        end else if (r_cmd >= scfd_pkg::CMD_STOP_FIRST && r_cmd <= scfd_pkg::CMD_STOP_LAST) begin
            dec_motor = scfd_pkg::MOTOR_W'(r_cmd[1:0] - 2'd1);
            dec_act   = value_is_one ? scfd_pkg::ACT_BRAKE : scfd_pkg::ACT_FLOAT;
        end else if (r_cmd >= scfd_pkg::CMD_RCNT_FIRST && r_cmd <= scfd_pkg::CMD_RCNT_LAST) begin
            dec_motor = scfd_pkg::MOTOR_W'(r_cmd[1:0] - 2'd1);
            dec_act   = scfd_pkg::ACT_RESET_CNT;
        end else if (r_cmd == scfd_pkg::CMD_COLOR) begin
            dec_act = scfd_pkg::ACT_COLOR;
        end else if (r_cmd == scfd_pkg::CMD_ULTRA) begin
            dec_act = scfd_pkg::ACT_ULTRA;
        end else if (r_cmd == scfd_pkg::CMD_GYRO_RST) begin
            dec_act = scfd_pkg::ACT_GYRO_RST;
            dec_imu = value_is_one;
        end else begin
            dec_act = scfd_pkg::ACT_OTHER;
        end
    end

    // Parser next state and result fields for the byte at the input.
    always_comb begin
        n_phase    = r_phase;
        n_cmd      = r_cmd;
        n_first    = r_first;
        n_byte_cnt = r_byte_cnt;
        n_fail_cnt = r_fail_cnt;
        n_done     = 1'b0;
        n_cid      = '0;
        n_fval     = '0;
        n_act      = scfd_pkg::ACT_NONE;
        n_motor    = '0;
        n_imu      = 1'b0;
        n_err      = 1'b0;
        unique case (r_phase)
            PH_DATA1, PH_DATA2: begin
                n_byte_cnt = r_byte_cnt + CW'(1);
                if (marked) begin
                    // A command byte in a data position restarts the frame.
                    n_cmd      = low7;
                    n_fail_cnt = r_fail_cnt + CW'(1);
                    n_err      = 1'b1;
                    n_phase    = PH_DATA1;
                end else if (r_phase == PH_DATA1) begin
                    n_first = low7;
                    n_phase = PH_DATA2;
                end else begin
                    n_phase = PH_HUNT;
                    if (!in_range) begin
                        n_fail_cnt = r_fail_cnt + CW'(1);
                        n_err      = 1'b1;
                    end else begin
                        n_done  = 1'b1;
                        n_cid   = r_cmd;
                        n_fval  = value;
                        n_act   = dec_act;
                        n_motor = dec_motor;
                        n_imu   = dec_imu;
                    end
                end
            end
            default: begin
                n_phase = PH_HUNT;
                if (marked) begin
                    n_cmd   = low7;
                    n_phase = PH_DATA1;
                end
            end
        endcase
    end

    // Parse state, counters, configuration and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HUNT;
            r_cmd         <= '0;
            r_first       <= '0;
            r_byte_cnt    <= '0;
            r_fail_cnt    <= '0;
            r_power_limit <= scfd_pkg::POWER_LIMIT_INIT;
            r_valid       <= 1'b0;
            r_done        <= 1'b0;
            r_cid         <= '0;
            r_fval        <= '0;
            r_act         <= scfd_pkg::ACT_NONE;
            r_motor       <= '0;
            r_imu         <= 1'b0;
            r_err         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_power_limit <= i_cfg_wdata;
            end
            if (in_xfer) begin
                r_phase    <= n_phase;
                r_cmd      <= n_cmd;
                r_first    <= n_first;
                r_byte_cnt <= n_byte_cnt;
                r_fail_cnt <= n_fail_cnt;
                r_done     <= n_done;
                r_cid      <= n_cid;
                r_fval     <= n_fval;
                r_act      <= n_act;
                r_motor    <= n_motor;
                r_imu      <= n_imu;
                r_err      <= n_err;
            end
            if (o_s_axis_tready) begin
                r_valid <= i_s_axis_tvalid;
            end
        end
    end

    // Counters only move on an input transfer, which cannot happen while a
    // result is stalled, so the result reads them directly.
    generate
        if (CW >= scfd_pkg::CNT_OUT_W) begin : g_cnt_wide
            assign bytes_out = r_byte_cnt[scfd_pkg::CNT_OUT_W-1:0];
            assign fails_out = r_fail_cnt[scfd_pkg::CNT_OUT_W-1:0];
        end else begin : g_cnt_narrow
            assign bytes_out = {{(scfd_pkg::CNT_OUT_W - CW){1'b0}}, r_byte_cnt};
            assign fails_out = {{(scfd_pkg::CNT_OUT_W - CW){1'b0}}, r_fail_cnt};
        end
    endgenerate

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tlast  = r_done;
    assign o_m_axis_tuser  = r_err;
    assign o_m_axis_tdata  = {{(scfd_pkg::OUT_DATA_W - scfd_pkg::OUT_FIELDS_W){1'b0}},
                              fails_out, bytes_out, r_imu, r_motor, r_act, r_fval, r_cid};

    // A result never reports both a completed frame and a failure.
    `SCFD_ASSERT_NOW(a_done_err_excl, i_clk, i_rst_n, r_valid && r_done, !r_err)
    // Without a completed frame the decoded fields are all zero.
    `SCFD_ASSERT_NOW(a_idle_fields_zero, i_clk, i_rst_n, r_valid && !r_done,
        r_cid == '0 && r_fval == '0 && r_act == scfd_pkg::ACT_NONE && r_motor == '0 && !r_imu)
    // Every input transfer yields a result in the next cycle.
    `SCFD_ASSERT_NEXT(a_xfer_gives_result, i_clk, i_rst_n, in_xfer, r_valid)
    // An unmarked byte while hunting is not counted.
    `SCFD_ASSERT_NEXT(a_hunt_no_count, i_clk, i_rst_n,
        in_xfer && r_phase == PH_HUNT && !marked, r_byte_cnt == $past(r_byte_cnt))

endmodule

`default_nettype wire

FILE: tb/tb_serial_command_frame_decoder_top.sv
`default_nettype none

module tb_serial_command_frame_decoder_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 500000;

    // One decoded result, one field per output of the block.
    typedef struct packed {
        logic                                frame_done;
        logic [scfd_pkg::ID_W-1:0]           command_id;
        logic signed [scfd_pkg::VALUE_W-1:0] frame_value;
        logic [scfd_pkg::ACTION_W-1:0]       action;
        logic [scfd_pkg::MOTOR_W-1:0]        motor_index;
        logic                                imu_reinit;
        logic                                frame_error;
        logic [scfd_pkg::CNT_OUT_W-1:0]      bytes_counted;
        logic [scfd_pkg::CNT_OUT_W-1:0]      failures_counted;
    } t_decoded_frame;

    // Tracks the parser state and holds the results still owed by the block.
    class t_decode_scoreboard;
        logic [scfd_pkg::LIMIT_W-1:0]   power_limit;
        logic [1:0]                     parse_phase;
        logic [scfd_pkg::ID_W-1:0]      held_command;
        logic [scfd_pkg::ID_W-1:0]      held_first_data;
        logic [scfd_pkg::CNT_OUT_W-1:0] byte_count;
        logic [scfd_pkg::CNT_OUT_W-1:0] failure_count;
        t_decoded_frame                 expected_results[$];
        int                             mismatch_count;

        function new();
            power_limit     = scfd_pkg::POWER_LIMIT_INIT;
            parse_phase     = 2'd0;
            held_command    = '0;
            held_first_data = '0;
            byte_count      = '0;
            failure_count   = '0;
            mismatch_count  = 0;
        endfunction

        function int pending_count();
            return expected_results.size();
        endfunction

        function string describe(t_decoded_frame r);
            return $sformatf({"done=%0d id=%0d value=%0d action=%0d motor=%0d imu=%0d",
                              " err=%0d bytes=%0d fails=%0d"},
                r.frame_done, r.command_id, r.frame_value, r.action, r.motor_index,
                r.imu_reinit, r.frame_error, r.bytes_counted, r.failures_counted);
        endfunction

        // Advances the parser by one received byte and queues the result it causes.
        function void note_rx_byte(logic [scfd_pkg::BYTE_W-1:0] rx);
            t_decoded_frame r;
            logic [scfd_pkg::MAG_W-1:0] mag;
            logic [scfd_pkg::ID_W-1:0]  id;
            int m;
            int v;
            r = '0;
            if (parse_phase == 2'd1 || parse_phase == 2'd2) begin
                byte_count = byte_count + 1'b1;
                if (rx[7]) begin
                    // A marked byte in a data position restarts the frame.
                    held_command  = rx[6:0];
                    failure_count = failure_count + 1'b1;
                    r.frame_error = 1'b1;
                    parse_phase   = 2'd1;
                end else if (parse_phase == 2'd1) begin
                    held_first_data = rx[6:0];
                    parse_phase     = 2'd2;
                end else begin
                    mag = {held_first_data[4:0], rx[6:0]};
                    m   = int'(mag);
                    v   = held_first_data[5] ? -m : m;
                    parse_phase = 2'd0;
                    if (v < -2048 || v > 2048) begin
                        failure_count = failure_count + 1'b1;
                        r.frame_error = 1'b1;
                    end else begin
                        id            = held_command;
                        r.frame_done  = 1'b1;
                        r.command_id  = id;
                        r.frame_value = scfd_pkg::VALUE_W'(v);
                        if (id >= scfd_pkg::CMD_POWER_FIRST &&
                            id <= scfd_pkg::CMD_POWER_LAST) begin
                            r.motor_index = scfd_pkg::MOTOR_W'(id - scfd_pkg::CMD_POWER_FIRST);
                            r.action = (m <= int'(power_limit)) ? scfd_pkg::ACT_SET_POWER
                                                                : scfd_pkg::ACT_POWER_IGN;
                        end else if (id >= scfd_pkg::CMD_STOP_FIRST &&
                                     id <= scfd_pkg::CMD_STOP_LAST) begin
                            r.motor_index = scfd_pkg::MOTOR_W'(id - scfd_pkg::CMD_STOP_FIRST);
                            r.action = (v == 1) ? scfd_pkg::ACT_BRAKE : scfd_pkg::ACT_FLOAT;
                        end else if (id >= scfd_pkg::CMD_RCNT_FIRST &&
                                     id <= scfd_pkg::CMD_RCNT_LAST) begin
                            r.motor_index = scfd_pkg::MOTOR_W'(id - scfd_pkg::CMD_RCNT_FIRST);
                            r.action = scfd_pkg::ACT_RESET_CNT;
                        end else if (id == scfd_pkg::CMD_COLOR) begin
                            r.action = scfd_pkg::ACT_COLOR;
                        end else if (id == scfd_pkg::CMD_ULTRA) begin
                            r.action = scfd_pkg::ACT_ULTRA;
                        end else if (id == scfd_pkg::CMD_GYRO_RST) begin
                            r.action     = scfd_pkg::ACT_GYRO_RST;
                            r.imu_reinit = (v == 1);
                        end else begin
                            r.action = scfd_pkg::ACT_OTHER;
                        end
                    end
                end
            end else begin
                // Hunting: only a marked byte opens a frame.
                parse_phase = 2'd0;
                if (rx[7]) begin
                    held_command = rx[6:0];
                    parse_phase  = 2'd1;
                end
            end
            r.bytes_counted    = byte_count;
            r.failures_counted = failure_count;
            expected_results.push_back(r);
        endfunction

        // Compares one result from the block with the oldest expectation.
        function void check_decoded(t_decoded_frame got);
            t_decoded_frame want;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result with nothing pending: %s", describe(got));
                return;
            end
            want = expected_results.pop_front();
            if (got.frame_done !== want.frame_done || got.command_id !== want.command_id ||
                got.frame_value !== want.frame_value || got.action !== want.action ||
                got.motor_index !== want.motor_index || got.imu_reinit !== want.imu_reinit ||
                got.frame_error !== want.frame_error ||
                got.bytes_counted !== want.bytes_counted ||
                got.failures_counted !== want.failures_counted) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("decode mismatch");
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(got));
                end
            end
        endfunction
    endclass

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic [scfd_pkg::LIMIT_W-1:0]      i_cfg_wdata;
    logic                              i_s_axis_tvalid;
    logic                              o_s_axis_tready;
    logic [scfd_pkg::BYTE_W-1:0]       i_s_axis_tdata;
    logic                              o_m_axis_tvalid;
    logic                              i_m_axis_tready;
    logic [scfd_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata;
    logic                              o_m_axis_tlast;
    logic                              o_m_axis_tuser;

    t_decode_scoreboard decoder_sb;
    int                 sent_items;
    int                 hold_off_req;
    bit                 no_idle;
    int unsigned        cycle_count;

    // Frames that hit the limits and the special cases, with the reset power limit.
    logic [scfd_pkg::BYTE_W-1:0] directed_bytes [0:27] = '{
        8'h81, 8'h00, 8'h64,         // power at exactly the limit
        8'h83, 8'h30, 8'h00,         // power at -2048, beyond the limit
        8'h85, 8'h00, 8'h01,         // brake
        8'h8A, 8'h10, 8'h00,         // reset count at +2048
        8'h81, 8'h10, 8'h01,         // 2049 is out of range
        8'h8D, 8'h00, 8'h01,         // gyro reset with re-init
        8'h81, 8'h8D, 8'h20, 8'h00,  // restart in a data position, then negative zero
        8'hBE, 8'h7F, 8'h7F,         // largest negative magnitude, out of range
        8'hFF, 8'h40, 8'h07          // unknown command, ignored bit 6 set
    };

    serial_command_frame_decoder_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Clock with a 2 ns period.
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Hard limit on the run length.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones, none while idling is switched off.
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sample both handshakes at each rising edge.
    always @(posedge i_clk) begin
        t_decoded_frame got;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.frame_done       = o_m_axis_tlast;
                got.command_id       = o_m_axis_tdata[6:0];
                got.frame_value      = o_m_axis_tdata[19:7];
                got.action           = o_m_axis_tdata[23:20];
                got.motor_index      = o_m_axis_tdata[25:24];
                got.imu_reinit       = o_m_axis_tdata[26];
                got.frame_error      = o_m_axis_tuser;
                got.bytes_counted    = o_m_axis_tdata[58:27];
                got.failures_counted = o_m_axis_tdata[90:59];
                decoder_sb.check_decoded(got);
            end
            if (i_s_axis_tvalid && o_s_axis_tready)
                decoder_sb.note_rx_byte(i_s_axis_tdata);
        end
    end

    // Result side: random ready pattern, plus a long hold-off on request.
    initial begin : result_receiver
        int gap;
        int run;
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_off_req != 0) begin
                n = hold_off_req;
                hold_off_req = 0;
                i_m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
                i_m_axis_tready <= 1'b1;
            end else begin
                gap = pick_gap();
                if (gap != 0) begin
                    i_m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                i_m_axis_tready <= 1'b1;
                run = $urandom_range(1, 12);
                repeat (run - 1) @(posedge i_clk);
            end
        end
    end

    // Offers one byte and holds it until the transfer, then maybe idles.
    task automatic send_byte(input logic [scfd_pkg::BYTE_W-1:0] rx);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= rx;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sent_items++;
        gap = pick_gap();
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stops offering bytes until every owed result has been taken.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (decoder_sb.pending_count() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Writes the power limit while the block is idle.
    task automatic write_limit(input logic [scfd_pkg::LIMIT_W-1:0] limit);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= limit;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        decoder_sb.power_limit = limit;
    endtask

    // Mostly well-formed frames with random content, some noise and broken frames.
    task automatic send_random_items(input int count);
        int stop_at;
        int kind;
        int mag;
        int lim;
        logic [scfd_pkg::ID_W-1:0]  id;
        logic [scfd_pkg::MAG_W-1:0] mag_bits;
        stop_at = sent_items + count;
        while (sent_items < stop_at) begin
            kind = $urandom_range(0, 99);
            if (kind < 10) begin
                send_byte(scfd_pkg::BYTE_W'($urandom_range(0, 255)));
            end else if (kind < 16) begin
                send_byte({1'b1, scfd_pkg::ID_W'($urandom)});
                if ($urandom_range(0, 1) == 1)
                    send_byte({1'b0, scfd_pkg::ID_W'($urandom)});
                send_byte({1'b1, scfd_pkg::ID_W'($urandom)});
            end else begin
                case ($urandom_range(0, 9))
                    0, 7, 8: id = scfd_pkg::CMD_POWER_FIRST
                                  + scfd_pkg::ID_W'($urandom_range(0, 2));
                    1, 9:    id = scfd_pkg::CMD_STOP_FIRST
                                  + scfd_pkg::ID_W'($urandom_range(0, 2));
                    2:       id = scfd_pkg::CMD_RCNT_FIRST
                                  + scfd_pkg::ID_W'($urandom_range(0, 2));
                    3:       id = scfd_pkg::CMD_GYRO_RST;
                    4:       id = scfd_pkg::CMD_COLOR;
                    5:       id = scfd_pkg::CMD_ULTRA;
                    default: id = scfd_pkg::ID_W'($urandom);
                endcase
                case ($urandom_range(0, 9))
                    0, 1, 2: mag = $urandom_range(0, 2);
                    3, 4: begin
                        lim = int'(decoder_sb.power_limit);
                        mag = lim + $urandom_range(0, 2) - 1;
                        if (mag < 0) mag = 0;
                    end
                    5:       mag = $urandom_range(2046, 2050);
                    6:       mag = $urandom_range(0, 4095);
                    default: mag = $urandom_range(0, 2048);
                endcase
                mag_bits = scfd_pkg::MAG_W'(mag);
                send_byte({1'b1, id});
                send_byte({1'b0, 1'($urandom), 1'($urandom), mag_bits[11:7]});
                send_byte({1'b0, mag_bits[6:0]});
            end
        end
    endtask

    // Main sequence: reset, directed frames, then random phases at several limits.
    initial begin : stimulus
        decoder_sb      = new();
        sent_items      = 0;
        hold_off_req    = 0;
        no_idle         = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_bytes[k])
            send_byte(directed_bytes[k]);

        // Hold the result side off while bytes keep coming, so the input stalls.
        drain();
        hold_off_req = 200;
        wait (hold_off_req == 0);
        no_idle = 1'b1;
        send_random_items(40);
        no_idle = 1'b0;

        write_limit(12'd0);
        send_random_items(280);

        write_limit(12'd2048);
        no_idle = 1'b1;
        send_random_items(100);
        no_idle = 1'b0;
        send_random_items(200);

        write_limit(scfd_pkg::LIMIT_W'($urandom_range(0, 2048)));
        send_random_items(280);

        write_limit(12'd1);
        send_random_items(240);

        drain();
        if (decoder_sb.mismatch_count == 0 && decoder_sb.pending_count() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+hw/rtl
hw/rtl/scfd_pkg.sv
hw/rtl/serial_command_frame_decoder_top.sv
tb/tb_serial_command_frame_decoder_top.sv
